/* rtl/edn_pkg.sv */
// Shared types, constants and calendar helpers for the epoch day number converter.
package edn_pkg;

   localparam int unsigned EPOCH_YEAR        = 1970;
   localparam int unsigned DEFAULT_LAST_YEAR = 2099;
   localparam int unsigned DAYS_YEAR         = 365;
   localparam int unsigned DAYS_LEAP_YEAR    = 366;
   localparam int unsigned MONTHS_PER_YEAR   = 12;
   localparam int unsigned DAYS_PER_WEEK     = 7;
   localparam int unsigned EPOCH_WEEKDAY     = 4;
   localparam int unsigned LEAP_CYCLE        = 4;
   localparam int unsigned CENTURY           = 100;
   localparam int unsigned QUAD_CENTURY      = 400;
   localparam int unsigned NUM_MAX           = 65535;

   typedef logic [11:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [15:0] num_type;
   typedef logic [16:0] acc_type;
   typedef logic [8:0]  ylen_type;
   typedef logic [2:0]  wd_type;
   typedef logic [1:0]  c4_type;
   typedef logic [6:0]  c100_type;
   typedef logic [8:0]  c400_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTHS,
      ST_FINISH
   } state_type;

   typedef enum logic {
      OP_DATE_TO_NUM = 1'b0,
      OP_NUM_TO_DATE = 1'b1
   } op_type;

   typedef struct packed {
      op_type    op;
      year_type  year_in;
      month_type month_in;
      day_type   day_in;
      num_type   day_number_in;
   } req_type;

   typedef struct packed {
      num_type   day_number_out;
      year_type  year_out;
      month_type month_out;
      day_type   day_out;
      wd_type    weekday;
      logic      valid_res;
   } rsp_type;

   function automatic day_type month_days(month_type m, logic leap);
      day_type d;
      unique case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic wd_type mod7_small(day_type v);
      day_type r;
      r = v;
      if (r >= 5'd28) r = r - 5'd28;
      if (r >= 5'd14) r = r - 5'd14;
      if (r >= 5'd7)  r = r - 5'd7;
      return r[2:0];
   endfunction

   function automatic wd_type wd_add(wd_type a, wd_type b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) s = s - 4'd7;
      return s[2:0];
   endfunction

endpackage

/* rtl/edn_req_if.sv */
// Request channel interface carrying one conversion item.
interface edn_req_if;
   logic             valid;
   logic             ready;
   edn_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/edn_rsp_if.sv */
// Response channel interface carrying one conversion result.
interface edn_rsp_if;
   logic             valid;
   logic             ready;
   edn_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/epoch_day_number_converter.sv */
// Date to day number steps the years from 1970 up to the target year, then the months up to the
// target month; day number to date steps the years from 1970, then the months, to the date.
// Both then load the result; an item rejected on its fields goes straight to loading its result.
// Throughput: one item at a time, the next taken in the cycle after its result is loaded, paced
// by the year stepping loop through the single shared add/subtract unit; a held result stalls.
// Reset (synchronous) returns the sequencer to idle and drops any pending result.
module epoch_day_number_converter #(
   parameter int unsigned LAST_YEAR = edn_pkg::DEFAULT_LAST_YEAR
) (
   input logic        clock,
   input logic        reset,
   edn_req_if.sink    req_bus,
   edn_rsp_if.source  rsp_bus
);

   localparam edn_pkg::year_type EPOCH_Y = edn_pkg::year_type'(edn_pkg::EPOCH_YEAR);
   localparam edn_pkg::year_type LAST_Y  = edn_pkg::year_type'(LAST_YEAR);
   localparam edn_pkg::c4_type   C4_INIT =
      edn_pkg::c4_type'(edn_pkg::EPOCH_YEAR % edn_pkg::LEAP_CYCLE);
   localparam edn_pkg::c100_type C100_INIT =
      edn_pkg::c100_type'(edn_pkg::EPOCH_YEAR % edn_pkg::CENTURY);
   localparam edn_pkg::c400_type C400_INIT =
      edn_pkg::c400_type'(edn_pkg::EPOCH_YEAR % edn_pkg::QUAD_CENTURY);
   localparam edn_pkg::c100_type C100_LAST = edn_pkg::c100_type'(edn_pkg::CENTURY - 1);
   localparam edn_pkg::c400_type C400_LAST = edn_pkg::c400_type'(edn_pkg::QUAD_CENTURY - 1);
   localparam edn_pkg::wd_type   WD_INIT   = edn_pkg::wd_type'(edn_pkg::EPOCH_WEEKDAY - 1);
   localparam edn_pkg::month_type LAST_M   = edn_pkg::month_type'(edn_pkg::MONTHS_PER_YEAR);
   localparam edn_pkg::acc_type  ACC_MAX   = edn_pkg::acc_type'(edn_pkg::NUM_MAX);

   edn_pkg::state_type state_ff, state_in;
   edn_pkg::op_type    op_ff, op_in;
   edn_pkg::year_type  year_tgt_ff, year_tgt_in;
   edn_pkg::month_type month_tgt_ff, month_tgt_in;
   edn_pkg::day_type   day_tgt_ff, day_tgt_in;
   edn_pkg::num_type   num_ff, num_in;
   edn_pkg::year_type  year_ff, year_in;
   edn_pkg::c4_type    c4_ff, c4_in;
   edn_pkg::c100_type  c100_ff, c100_in;
   edn_pkg::c400_type  c400_ff, c400_in;
   edn_pkg::month_type month_ff, month_in;
   edn_pkg::acc_type   acc_ff, acc_in;
   edn_pkg::wd_type    wd_ff, wd_in;
   logic               ok_ff, ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   edn_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               leap;
   edn_pkg::ylen_type  ylen;
   edn_pkg::day_type   dim;
   edn_pkg::acc_type   operand;
   edn_pkg::acc_type   acc_sum;
   logic               acc_gt;
   logic               req_take;
   logic               bad_req;
   edn_pkg::req_type   req;

   assign req     = req_bus.data;
   assign leap    = (c4_ff == '0) && ((c100_ff != '0) || (c400_ff == '0));
   assign ylen    = leap ? edn_pkg::ylen_type'(edn_pkg::DAYS_LEAP_YEAR)
                         : edn_pkg::ylen_type'(edn_pkg::DAYS_YEAR);
   assign dim     = edn_pkg::month_days(month_ff, leap);

   always_comb begin
      if (state_ff == edn_pkg::ST_YEARS) begin
         operand = edn_pkg::acc_type'(ylen);
      end else if (op_ff == edn_pkg::OP_DATE_TO_NUM && month_ff == month_tgt_ff) begin
         operand = edn_pkg::acc_type'(day_tgt_ff);
      end else begin
         operand = edn_pkg::acc_type'(dim);
      end
   end

   assign acc_sum = (op_ff == edn_pkg::OP_DATE_TO_NUM) ? acc_ff + operand : acc_ff - operand;
   assign acc_gt  = acc_ff > operand;

   assign req_bus.ready = (state_ff == edn_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   always_comb begin
      if (req.op == edn_pkg::OP_DATE_TO_NUM) begin
         bad_req = (req.year_in < EPOCH_Y) || (req.year_in > LAST_Y) ||
                   (req.month_in == '0) || (req.month_in > LAST_M) || (req.day_in == '0);
      end else begin
         bad_req = (req.day_number_in == '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      year_tgt_in  = year_tgt_ff;
      month_tgt_in = month_tgt_ff;
      day_tgt_in   = day_tgt_ff;
      num_in       = num_ff;
      year_in      = year_ff;
      c4_in        = c4_ff;
      c100_in      = c100_ff;
      c400_in      = c400_ff;
      month_in     = month_ff;
      acc_in       = acc_ff;
      wd_in        = wd_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         edn_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in        = req.op;
               year_tgt_in  = req.year_in;
               month_tgt_in = req.month_in;
               day_tgt_in   = req.day_in;
               num_in       = req.day_number_in;
               year_in      = EPOCH_Y;
               c4_in        = C4_INIT;
               c100_in      = C100_INIT;
               c400_in      = C400_INIT;
               month_in     = edn_pkg::month_type'(1);
               wd_in        = WD_INIT;
               acc_in       = (req.op == edn_pkg::OP_DATE_TO_NUM) ? '0
                                 : edn_pkg::acc_type'(req.day_number_in);
               ok_in        = 1'b0;
               state_in     = bad_req ? edn_pkg::ST_FINISH : edn_pkg::ST_YEARS;
            end
         end
         edn_pkg::ST_YEARS: begin
            if ((op_ff == edn_pkg::OP_DATE_TO_NUM) ? (year_ff == year_tgt_ff)
                                                   : !acc_gt) begin
               state_in = edn_pkg::ST_MONTHS;
            end else if (op_ff == edn_pkg::OP_NUM_TO_DATE && year_ff >= LAST_Y) begin
               ok_in    = 1'b0;
               state_in = edn_pkg::ST_FINISH;
            end else begin
               acc_in  = acc_sum;
               wd_in   = edn_pkg::wd_add(wd_ff, leap ? 3'd2 : 3'd1);
               year_in = year_ff + 1'b1;
               c4_in   = c4_ff + 1'b1;
               c100_in = (c100_ff == C100_LAST) ? '0 : c100_ff + 1'b1;
               c400_in = (c400_ff == C400_LAST) ? '0 : c400_ff + 1'b1;
            end
         end
         edn_pkg::ST_MONTHS: begin
            if (op_ff == edn_pkg::OP_DATE_TO_NUM) begin
               if (month_ff == month_tgt_ff) begin
                  acc_in   = acc_sum;
                  wd_in    = edn_pkg::wd_add(wd_ff, edn_pkg::mod7_small(day_tgt_ff));
                  ok_in    = (day_tgt_ff <= dim) && (acc_sum <= ACC_MAX);
                  state_in = edn_pkg::ST_FINISH;
               end else begin
                  acc_in   = acc_sum;
                  wd_in    = edn_pkg::wd_add(wd_ff, edn_pkg::mod7_small(dim));
                  month_in = month_ff + 1'b1;
               end
            end else begin
               if (month_ff < LAST_M && acc_gt) begin
                  acc_in   = acc_sum;
                  wd_in    = edn_pkg::wd_add(wd_ff, edn_pkg::mod7_small(dim));
                  month_in = month_ff + 1'b1;
               end else begin
                  wd_in    = edn_pkg::wd_add(wd_ff, edn_pkg::mod7_small(acc_ff[4:0]));
                  ok_in    = 1'b1;
                  state_in = edn_pkg::ST_FINISH;
               end
            end
         end
         edn_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (ok_ff) begin
                  rsp_data_in.day_number_out = (op_ff == edn_pkg::OP_DATE_TO_NUM)
                                                  ? acc_ff[15:0] : num_ff;
                  rsp_data_in.year_out       = year_ff;
                  rsp_data_in.month_out      = month_ff;
                  rsp_data_in.day_out        = (op_ff == edn_pkg::OP_DATE_TO_NUM)
                                                  ? day_tgt_ff : acc_ff[4:0];
                  rsp_data_in.weekday        = wd_ff;
                  rsp_data_in.valid_res      = 1'b1;
               end
               state_in = edn_pkg::ST_IDLE;
            end
         end
         default: state_in = edn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      year_tgt_ff  <= year_tgt_in;
      month_tgt_ff <= month_tgt_in;
      day_tgt_ff   <= day_tgt_in;
      num_ff       <= num_in;
      year_ff      <= year_in;
      c4_ff        <= c4_in;
      c100_ff      <= c100_in;
      c400_ff      <= c400_in;
      month_ff     <= month_in;
      acc_ff       <= acc_in;
      wd_ff        <= wd_in;
      ok_ff        <= ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != edn_pkg::ST_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_month_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == edn_pkg::ST_MONTHS |-> month_ff != '0 && month_ff <= LAST_M)
      else $error("month counter out of range");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != edn_pkg::ST_IDLE |-> wd_ff < 3'd7)
      else $error("weekday accumulator out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.valid_res |->
         rsp_data_ff.day_number_out == '0 && rsp_data_ff.year_out == '0 &&
         rsp_data_ff.month_out == '0 && rsp_data_ff.day_out == '0 &&
         rsp_data_ff.weekday == '0)
      else $error("invalid result carries non-zero fields");
`endif

endmodule
